### rtl/min_tracking_stack_macros.svh
// assertion helpers shared by the stack rtl
// each expects clk and arst_n in scope
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mts_pkg.sv
package mts_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// word field widths
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// request codes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_MIN  = 2'd2;

	// response status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

	// one stack level: value and running minimum down to the bottom
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] minimum;
	} level_t;

endpackage

### rtl/mts_req_if.sv
interface mts_req_if import mts_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

### rtl/mts_rsp_if.sv
interface mts_rsp_if import mts_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] result_value;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

### rtl/min_tracking_stack.sv
// channel | dir | fields                      | handshake
// req     | in  | op, push_value              | valid/ready
// rsp     | out | result_value, status        | valid/ready
//
// a pop that leaves the stack non-empty enters a refill state: the new top level
// comes back from the level ram in the cycle after the pop, and no request is taken then.
// the top level sits in registers, the levels below it in a one-port-each ram.
// reset clears the state, the fill count and the response valid; no ram clearing.
// a stalled response holds req.ready low until the word is taken.
module min_tracking_stack import mts_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	`include "min_tracking_stack_macros.svh"

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_REFILL = 1'b1;

	logic                      state_q;
	logic [CNT_W-1:0]          fill_q;
	logic signed [VALUE_W-1:0] top_val_q;
	logic signed [VALUE_W-1:0] top_min_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] result_q;
	logic [STATUS_W-1:0]       status_q;

	logic                      accept;
	logic                      is_empty;
	logic                      is_full;
	logic signed [VALUE_W-1:0] new_min;
	logic                      ram_we;
	logic                      ram_re;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [ADDR_W-1:0]         ram_raddr;
	level_t                    ram_wdata;
	level_t                    ram_rdata;
	logic signed [VALUE_W-1:0] result_d;
	logic [STATUS_W-1:0]       status_d;

	// handshake
	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_empty  = (fill_q == '0);
	assign is_full   = (fill_q == CNT_W'(STACK_DEPTH));

	// running minimum for a push
	assign new_min = (!is_empty && (top_min_q < req.push_value)) ? top_min_q
		: req.push_value;

	// spill old top on push, fetch next level on pop
	assign ram_we    = accept && (req.op == OP_PUSH) && !is_empty && !is_full;
	assign ram_waddr = ADDR_W'(fill_q - CNT_W'(1));
	assign ram_wdata = '{value: top_val_q, minimum: top_min_q};
	assign ram_re    = accept && (req.op == OP_POP) && (fill_q > CNT_W'(1));
	assign ram_raddr = ADDR_W'(fill_q - CNT_W'(2));

	mts_ram #(
		.DEPTH  (STACK_DEPTH),
		.DATA_W ($bits(level_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control: state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else if (state_q == ST_REFILL) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			unique case (req.op)
				OP_PUSH: begin
					if (!is_full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				OP_POP: begin
					if (!is_empty) begin
						fill_q <= fill_q - CNT_W'(1);
					end
					if (ram_re) begin
						state_q <= ST_REFILL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// top level registers
	always_ff @(posedge clk) begin
		if (state_q == ST_REFILL) begin
			top_val_q <= ram_rdata.value;
			top_min_q <= ram_rdata.minimum;
		end else if (accept && (req.op == OP_PUSH) && !is_full) begin
			top_val_q <= req.push_value;
			top_min_q <= new_min;
		end
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response word for the current request
	always_comb begin
		result_d = '0;
		status_d = STATUS_OK;
		unique case (req.op)
			OP_PUSH: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					result_d = EMPTY_VALUE;
					status_d = STATUS_EMPTY;
				end else begin
					result_d = top_val_q;
				end
			end
			OP_MIN: begin
				if (is_empty) begin
					result_d = EMPTY_VALUE;
					status_d = STATUS_EMPTY;
				end else begin
					result_d = top_min_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
			status_q <= status_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = result_q;
	assign rsp.status       = status_q;

	// checks
	`MTS_ASSERT_NEXT(a_pop_refill, accept && (req.op == OP_POP) && (fill_q > CNT_W'(1)),
		state_q == ST_REFILL, "deep pop did not enter refill")
	`MTS_ASSERT_NOW(a_refill_blocks, state_q == ST_REFILL, !req.ready,
		"request taken during refill")
	`MTS_ASSERT_NEXT(a_full_flag, accept && (req.op == OP_PUSH) && is_full,
		rsp.valid && (rsp.status == STATUS_FULL) && is_full, "full push not flagged")
	`MTS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(STACK_DEPTH),
		"fill count beyond depth")

endmodule

### rtl/mts_ram.sv
module mts_ram #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
